// ----- sv/xcrc_pkg.sv -----
// Package for the XMODEM-CRC block receiver: item types, phase encoding,
// protocol byte codes and the byte-wise CRC-16 update. No dependencies.
package xcrc_pkg;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_START   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    RPL_NONE = 2'd0,
    RPL_ACK  = 2'd1,
    RPL_NAK  = 2'd2,
    RPL_C    = 2'd3
  } reply_e;

  typedef enum logic [1:0] {
    ST_GOING   = 2'd0,
    ST_DONE    = 2'd1,
    ST_ABORTED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_HEADER  = 3'd1,
    PH_SEQ     = 3'd2,
    PH_SEQINV  = 3'd3,
    PH_BODY    = 3'd4,
    PH_STOPPED = 3'd7
  } phase_e;

  localparam logic [7:0]  CHR_SOH = 8'h01;
  localparam logic [7:0]  CHR_STX = 8'h02;
  localparam logic [7:0]  CHR_EOT = 8'h04;
  localparam logic [7:0]  SEQ_FIRST = 8'd1;
  localparam logic [8:0]  SEQ_SUM = 9'd255;
  localparam logic [10:0] BLK_LEN_SHORT = 11'd128;
  localparam logic [10:0] BLK_LEN_LONG  = 11'd1024;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] reply;
    logic [1:0] status;
    logic       payload_valid;
    logic [7:0] payload_byte;
  } out_item_t;

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- sv/xcrc_stream_if.sv -----
// Valid/ready stream channel carrying one packed payload.
// Payload type is a parameter; users take types from xcrc_pkg.
interface xcrc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/xmodem_crc_block_receiver_top.sv -----
// XMODEM-CRC block receiver: one event in, one result out.
// Each item passes through an input register and then a result register before its result is valid.
// Throughput: one item per cycle while the output is not stalled; the step logic updates protocol state per item.
// Reset (async, active low) clears both stages and returns to awaiting first byte.
// Depends on xcrc_pkg, xcrc_stream_if and xcrc_fsm.
module xmodem_crc_block_receiver_top import xcrc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  xcrc_stream_if.sink   in_ch,
  xcrc_stream_if.source out_ch
);

  logic      in_vld_q;
  in_item_t  in_item_q;
  logic      out_vld_q;
  out_item_t out_item_q;
  out_item_t step_res;
  logic      advance;

  // step the held item when the result register can take it
  assign advance     = in_vld_q && (!out_vld_q || out_ch.ready);
  assign in_ch.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_q <= in_ch.payload;
    end
  end

  xcrc_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_item_q),
    .result_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= step_res;
    end
  end

  assign out_ch.valid   = out_vld_q;
  assign out_ch.payload = out_item_q;

endmodule

// ----- sv/xcrc_fsm.sv -----
// Protocol state of the receiver and the per-byte step logic.
// Depends on xcrc_pkg for phase codes, byte codes and crc_add.
module xcrc_fsm import xcrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_en_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  exp_seq_q, exp_seq_d;
  logic        long_blk_q, long_blk_d;
  logic [10:0] byte_cnt_q, byte_cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  status_e     status_q, status_d;

  phase_e      ph_eff;
  logic [10:0] blk_len;
  logic        in_payload;
  logic        at_crc_hi;
  logic        crc_ok;
  logic        seq_inv_ok;
  logic [7:0]  ch;

  assign ch         = item_i.rx_byte;
  assign ph_eff     = (phase_q == PH_FIRST) ? PH_HEADER : phase_q;
  assign blk_len    = long_blk_q ? BLK_LEN_LONG : BLK_LEN_SHORT;
  assign in_payload = byte_cnt_q < blk_len;
  assign at_crc_hi  = byte_cnt_q == blk_len;
  assign crc_ok     = {crc_hi_q, ch} == crc_q;
  assign seq_inv_ok = ({1'b0, ch} + {1'b0, exp_seq_q}) == SEQ_SUM;

  // next state
  always_comb begin
    phase_d    = phase_q;
    exp_seq_d  = exp_seq_q;
    long_blk_d = long_blk_q;
    byte_cnt_d = byte_cnt_q;
    crc_d      = crc_q;
    crc_hi_d   = crc_hi_q;
    status_d   = status_q;
    case (item_i.operation)
      OP_START: begin
        phase_d    = PH_FIRST;
        exp_seq_d  = SEQ_FIRST;
        long_blk_d = 1'b0;
        byte_cnt_d = '0;
        crc_d      = '0;
        crc_hi_d   = '0;
        status_d   = ST_GOING;
      end
      OP_TIMEOUT: begin
        if (phase_q == PH_FIRST) begin
          phase_d  = PH_STOPPED;
          status_d = ST_ABORTED;
        end else if (phase_q != PH_STOPPED) begin
          phase_d    = PH_HEADER;
          byte_cnt_d = '0;
          crc_d      = '0;
          crc_hi_d   = '0;
        end
      end
      OP_BYTE: begin
        if (phase_q != PH_STOPPED) begin
          case (ph_eff)
            PH_HEADER: begin
              if (ch == CHR_EOT) begin
                phase_d  = PH_STOPPED;
                status_d = ST_DONE;
              end else if (ch == CHR_SOH || ch == CHR_STX) begin
                long_blk_d = (ch == CHR_STX);
                phase_d    = PH_SEQ;
              end else begin
                phase_d  = PH_STOPPED;
                status_d = ST_ABORTED;
              end
            end
            PH_SEQ: begin
              if (ch != exp_seq_q) begin
                phase_d  = PH_STOPPED;
                status_d = ST_ABORTED;
              end else begin
                phase_d = PH_SEQINV;
              end
            end
            PH_SEQINV: begin
              if (!seq_inv_ok) begin
                phase_d  = PH_STOPPED;
                status_d = ST_ABORTED;
              end else begin
                phase_d    = PH_BODY;
                byte_cnt_d = '0;
                crc_d      = '0;
                crc_hi_d   = '0;
              end
            end
            PH_BODY: begin
              if (in_payload) begin
                crc_d      = crc_add(crc_q, ch);
                byte_cnt_d = byte_cnt_q + 11'd1;
              end else if (at_crc_hi) begin
                crc_hi_d   = ch;
                byte_cnt_d = byte_cnt_q + 11'd1;
              end else if (!crc_ok) begin
                phase_d  = PH_STOPPED;
                status_d = ST_ABORTED;
              end else begin
                phase_d    = PH_HEADER;
                exp_seq_d  = exp_seq_q + 8'd1;
                byte_cnt_d = '0;
                crc_d      = '0;
                crc_hi_d   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    result_o               = '0;
    result_o.reply         = RPL_NONE;
    result_o.status        = status_d;
    case (item_i.operation)
      OP_START: result_o.reply = RPL_C;
      OP_TIMEOUT: begin
        if (phase_q != PH_FIRST && phase_q != PH_STOPPED) begin
          result_o.reply = RPL_NAK;
        end
      end
      OP_BYTE: begin
        if (phase_q != PH_STOPPED) begin
          if (ph_eff == PH_HEADER && ch == CHR_EOT) begin
            result_o.reply = RPL_ACK;
          end else if (ph_eff == PH_BODY) begin
            if (in_payload) begin
              result_o.payload_valid = 1'b1;
              result_o.payload_byte  = ch;
            end else if (!at_crc_hi && crc_ok) begin
              result_o.reply = RPL_ACK;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_FIRST;
      exp_seq_q  <= SEQ_FIRST;
      long_blk_q <= 1'b0;
      byte_cnt_q <= '0;
      crc_q      <= '0;
      crc_hi_q   <= '0;
      status_q   <= ST_GOING;
    end else if (step_en_i) begin
      phase_q    <= phase_d;
      exp_seq_q  <= exp_seq_d;
      long_blk_q <= long_blk_d;
      byte_cnt_q <= byte_cnt_d;
      crc_q      <= crc_d;
      crc_hi_q   <= crc_hi_d;
      status_q   <= status_d;
    end
  end

endmodule

// ----- sv/xcrc_checker.sv -----
// Port-level checks for the XMODEM-CRC receiver, bound to the top level.
// Depends on xcrc_pkg for reply and status codes.
module xcrc_checker import xcrc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] reply_i,
  input logic [1:0] status_i,
  input logic       payload_valid_i,
  input logic [7:0] payload_byte_i
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(reply_i) && $stable(status_i)
      && $stable(payload_valid_i) && $stable(payload_byte_i))
    else $error("stalled result changed");

  a_payload_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && payload_valid_i |-> reply_i == RPL_NONE && status_i == ST_GOING)
    else $error("payload byte with reply or terminal status");

  a_no_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !payload_valid_i |-> payload_byte_i == 8'h00)
    else $error("payload byte set without payload valid");

  a_start_going: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (reply_i == RPL_C || reply_i == RPL_NAK) |-> status_i == ST_GOING)
    else $error("start or NAK with terminal status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i == ST_GOING || status_i == ST_DONE || status_i == ST_ABORTED)
    else $error("status code out of range");

endmodule

bind xmodem_crc_block_receiver_top xcrc_checker u_xcrc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .reply_i         (out_ch.payload.reply),
  .status_i        (out_ch.payload.status),
  .payload_valid_i (out_ch.payload.payload_valid),
  .payload_byte_i  (out_ch.payload.payload_byte)
);

// ----- bench/tb_xmodem_crc_block_receiver_top.sv -----
// Testbench for xmodem_crc_block_receiver_top: drives XMODEM-CRC event streams,
// predicts each reply, status and payload byte, and checks them in order.
// Depends on xcrc_pkg, xcrc_stream_if and the receiver RTL.
module tb_xmodem_crc_block_receiver_top;
  import xcrc_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEM_TARGET  = 1000;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum int {
    FLT_NONE,
    FLT_TIMEOUT,
    FLT_BAD_HEADER,
    FLT_BAD_SEQ,
    FLT_BAD_SEQINV,
    FLT_BAD_CRC
  } fault_e;

  typedef enum int {
    RX_OPEN,
    RX_JITTER,
    RX_EVERY_THIRD,
    RX_STARVED
  } rx_mode_e;

  class xcrc_scoreboard;
    out_item_t   pending_replies[$];
    int unsigned errors;
    phase_e      phase;
    logic [7:0]  want_seq;
    logic        long_blk;
    logic [10:0] taken;
    logic [15:0] crc;
    logic [7:0]  crc_hi;
    status_e     term;

    function new();
      errors = 0;
      restart();
    endfunction

    static function logic [15:0] crc_byte(logic [15:0] acc, logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
        fb = r[15] ^ b[i];
        r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return r;
    endfunction

    function void drop_block();
      taken  = '0;
      crc    = '0;
      crc_hi = '0;
    endfunction

    function void restart();
      phase    = PH_FIRST;
      want_seq = SEQ_FIRST;
      long_blk = 1'b0;
      term     = ST_GOING;
      drop_block();
    endfunction

    function void halt(status_e s);
      phase = PH_STOPPED;
      term  = s;
    endfunction

    function out_item_t step_receiver(in_item_t ev);
      out_item_t   r;
      logic [10:0] blk_len;
      r = '0;
      r.reply = RPL_NONE;
      case (ev.operation)
        OP_START: begin
          restart();
          r.reply = RPL_C;
        end
        OP_TIMEOUT: begin
          if (phase == PH_FIRST) begin
            halt(ST_ABORTED);
          end else if (phase != PH_STOPPED) begin
            drop_block();
            r.reply = RPL_NAK;
            phase = PH_HEADER;
          end
        end
        OP_BYTE: begin
          if (phase != PH_STOPPED) begin
            if (phase == PH_FIRST) phase = PH_HEADER;
            case (phase)
              PH_HEADER: begin
                if (ev.rx_byte == CHR_EOT) begin
                  r.reply = RPL_ACK;
                  halt(ST_DONE);
                end else if (ev.rx_byte == CHR_SOH || ev.rx_byte == CHR_STX) begin
                  long_blk = (ev.rx_byte == CHR_STX);
                  phase = PH_SEQ;
                end else begin
                  halt(ST_ABORTED);
                end
              end
              PH_SEQ: begin
                if (ev.rx_byte != want_seq) halt(ST_ABORTED);
                else phase = PH_SEQINV;
              end
              PH_SEQINV: begin
                if ({1'b0, ev.rx_byte} + {1'b0, want_seq} != SEQ_SUM) begin
                  halt(ST_ABORTED);
                end else begin
                  drop_block();
                  phase = PH_BODY;
                end
              end
              default: begin
                blk_len = long_blk ? BLK_LEN_LONG : BLK_LEN_SHORT;
                if (taken < blk_len) begin
                  crc = crc_byte(crc, ev.rx_byte);
                  r.payload_valid = 1'b1;
                  r.payload_byte  = ev.rx_byte;
                  taken++;
                end else if (taken == blk_len) begin
                  crc_hi = ev.rx_byte;
                  taken++;
                end else if ({crc_hi, ev.rx_byte} != crc) begin
                  halt(ST_ABORTED);
                end else begin
                  // good trailer: commit and move on to the next block
                  drop_block();
                  r.reply = RPL_ACK;
                  phase = PH_HEADER;
                  want_seq++;
                end
              end
            endcase
          end
        end
        default: ;
      endcase
      r.status = term;
      return r;
    endfunction

    function void note_event(in_item_t ev);
      pending_replies.push_back(step_receiver(ev));
    endfunction

    function bit busy();
      return pending_replies.size() != 0;
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (pending_replies.size() == 0) begin
        $error("unexpected result: reply %0d status %0d payload_valid %0d payload_byte %0h",
               got.reply, got.status, got.payload_valid, got.payload_byte);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.reply !== want.reply) begin
        $error("reply: expected %0d, actual %0d", want.reply, got.reply);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.payload_valid !== want.payload_valid) begin
        $error("payload_valid: expected %0d, actual %0d", want.payload_valid, got.payload_valid);
        errors++;
      end
      if (got.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected %0h, actual %0h", want.payload_byte, got.payload_byte);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  xcrc_stream_if #(.payload_t(in_item_t))  in_ch ();
  xcrc_stream_if #(.payload_t(out_item_t)) out_ch ();

  xmodem_crc_block_receiver_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  xcrc_scoreboard sb = new();

  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count;
  bit          live = 1'b0;
  bit          long_used = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_reply(out_ch.payload);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: stall pattern changes every stretch; one long hold-off on request.
  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned tick;
    rx_mode_e    rx_mode;
    hold_left = 0;
    mode_left = 0;
    tick = 0;
    rx_mode = RX_OPEN;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(RX_OPEN, RX_STARVED));
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        tick++;
        case (rx_mode)
          RX_OPEN:        out_ch.ready <= 1'b1;
          RX_JITTER:      out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_EVERY_THIRD: out_ch.ready <= (tick % 3 == 0);
          default:        out_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  task automatic idle(int unsigned n);
    logic [31:0] junk;
    repeat (n) begin
      @(negedge clk_i);
      junk = $urandom;
      in_ch.valid   <= 1'b0;
      in_ch.payload <= junk[$bits(in_item_t)-1:0];
    end
  endtask

  // Hold input off until every pending result is out, then let the pipe settle.
  task automatic drain();
    idle(1);
    while (sb.busy()) idle(1);
    idle(DRAIN_CYCLES);
  endtask

  task automatic put(logic [1:0] op, logic [7:0] b);
    in_item_t ev;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
    end
    burst_left--;
    ev.operation = op;
    ev.rx_byte   = b;
    @(negedge clk_i);
    in_ch.valid   <= 1'b1;
    in_ch.payload <= ev;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.note_event(ev);
    if (live && op != OP_UNUSED) items_sent++;
    if (!hold_done && items_sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_req  = 1'b1;
    end
  endtask

  function automatic logic [7:0] nonzero_mask();
    logic [7:0] m;
    do m = 8'($urandom); while (m == 8'h00);
    return m;
  endfunction

  // Items the block ignores once it has stopped.
  task automatic stray_items();
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 2))
        0:       put(OP_BYTE, 8'($urandom));
        1:       put(OP_TIMEOUT, 8'($urandom));
        default: put(OP_UNUSED, 8'($urandom));
      endcase
    end
  endtask

  task automatic send_block(logic [7:0] seq, bit long_blk, fault_e f, int cut_min);
    logic [7:0]  frame[$];
    logic [7:0]  b;
    logic [15:0] crc;
    int          len;
    int          stop;
    frame = {};
    crc = '0;
    len = long_blk ? int'(BLK_LEN_LONG) : int'(BLK_LEN_SHORT);
    frame.push_back(long_blk ? CHR_STX : CHR_SOH);
    frame.push_back(seq);
    frame.push_back(~seq);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      frame.push_back(b);
      crc = xcrc_scoreboard::crc_byte(crc, b);
    end
    frame.push_back(crc[15:8]);
    frame.push_back(crc[7:0]);
    stop = frame.size();
    case (f)
      FLT_TIMEOUT: stop = $urandom_range(cut_min, frame.size() - 1);
      FLT_BAD_HEADER: begin
        do b = 8'($urandom); while (b == CHR_SOH || b == CHR_STX || b == CHR_EOT);
        frame[0] = b;
        stop = 1 + $urandom_range(0, 3);
      end
      FLT_BAD_SEQ: begin
        frame[1] ^= nonzero_mask();
        stop = 2 + $urandom_range(0, 3);
      end
      FLT_BAD_SEQINV: begin
        frame[2] ^= nonzero_mask();
        stop = 3 + $urandom_range(0, 3);
      end
      FLT_BAD_CRC: frame[frame.size() - 2 + $urandom_range(0, 1)] ^= nonzero_mask();
      default: ;
    endcase
    for (int i = 0; i < stop; i++) put(OP_BYTE, frame[i]);
    if (f == FLT_TIMEOUT) put(OP_TIMEOUT, 8'($urandom));
  endtask

  task automatic run_session();
    logic [7:0] seq;
    int         nblk;
    int         pick;
    bit         long_blk;
    fault_e     f;
    live = 1'b1;
    put(OP_START, 8'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      // timeout before the first byte gives up at once
      put(OP_TIMEOUT, 8'($urandom));
      live = 1'b0;
      stray_items();
      return;
    end
    seq = SEQ_FIRST;
    nblk = $urandom_range(1, 4);
    for (int i = 0; i < nblk; i++) begin
      if ($urandom_range(0, 19) == 0) put(OP_UNUSED, 8'($urandom));
      long_blk = !long_used && items_sent > 200 && $urandom_range(0, 5) == 0;
      if (long_blk) long_used = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 84) f = FLT_NONE;
      else if (pick < 90) f = FLT_TIMEOUT;
      else f = fault_e'($urandom_range(FLT_BAD_HEADER, FLT_BAD_CRC));
      // a timeout right after start would abort, so cut at least the header
      send_block(seq, long_blk, f, (i == 0) ? 1 : 0);
      if (f == FLT_TIMEOUT) begin
        send_block(seq, long_blk, FLT_NONE, 0);
      end else if (f != FLT_NONE) begin
        live = 1'b0;
        stray_items();
        return;
      end
      seq++;
    end
    if ($urandom_range(0, 3) != 0) begin
      put(OP_BYTE, CHR_EOT);
      live = 1'b0;
      stray_items();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // start, then timeout before any byte; sticky abort ignores what follows
    put(OP_START, 8'h00);
    put(OP_TIMEOUT, 8'hFF);
    put(OP_BYTE, 8'hFF);
    put(OP_TIMEOUT, 8'h00);
    put(OP_UNUSED, 8'hA5);
    // bad header
    put(OP_START, 8'hFF);
    put(OP_BYTE, 8'h00);
    // EOT finishes; status stays
    put(OP_START, 8'h5A);
    put(OP_BYTE, CHR_EOT);
    put(OP_BYTE, CHR_SOH);
    // wrong sequence number
    put(OP_START, 8'h00);
    put(OP_BYTE, CHR_SOH);
    put(OP_BYTE, 8'h80);
    // wrong complement
    put(OP_START, 8'h00);
    put(OP_BYTE, CHR_STX);
    put(OP_BYTE, SEQ_FIRST);
    put(OP_BYTE, 8'h00);
    // timeouts in sequence, body and header phases, then EOT
    put(OP_START, 8'h00);
    put(OP_BYTE, CHR_SOH);
    put(OP_TIMEOUT, 8'h00);
    put(OP_BYTE, CHR_SOH);
    put(OP_BYTE, SEQ_FIRST);
    put(OP_BYTE, ~SEQ_FIRST);
    put(OP_BYTE, 8'hFF);
    put(OP_BYTE, 8'h00);
    put(OP_TIMEOUT, 8'hFF);
    put(OP_TIMEOUT, 8'h00);
    put(OP_BYTE, CHR_EOT);
    drain();

    while (items_sent < ITEM_TARGET) begin
      run_session();
      if ($urandom_range(0, 7) == 0) drain();
    end
    drain();

    if (sb.errors == 0 && !sb.busy()) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
